// ===== rtl/ldrs_pkg.sv =====
package ldrs_pkg;

    localparam int POS_W  = 12;
    localparam int LEN_W  = 13;
    localparam int BASE_W = 32;
    localparam int CODE_W = 16;
    localparam int CLS_W  = 2;
    localparam int TYPE_W = 2;
    localparam int MASK_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int TRACKERS = 3;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 3;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CLS_W-1:0] CLS_ENG = 2'd0;
    localparam logic [CLS_W-1:0] CLS_DIG = 2'd1;
    localparam logic [CLS_W-1:0] CLS_UNK = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_ENG = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_DIG = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_MIX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LETTER_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_HI    = 2'd3;

    localparam logic [MASK_W-1:0] LETTER_LO_RST = 64'd114658446934016;
    localparam logic [MASK_W-1:0] LETTER_HI_RST = 64'd2147483649;
    localparam logic [MASK_W-1:0] NUM_LO_RST    = 64'd87960930222080;
    localparam logic [MASK_W-1:0] NUM_HI_RST    = 64'd0;

    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] begin_pos;
        logic [LEN_W-1:0] length;
    } lex_t;

    typedef struct packed {
        logic [BASE_W-1:0]     base;
        logic                  lock;
        lex_t [TRACKERS-1:0]   lexes;
    } entry_t;

    // Codes of 0x80 and above are never connectors.
    function automatic logic conn_hit(input logic [MASK_W-1:0] lo,
                                      input logic [MASK_W-1:0] hi,
                                      input logic [CODE_W-1:0] code);
        logic bit_val;
        bit_val = code[6] ? hi[code[5:0]] : lo[code[5:0]];
        return (code[CODE_W-1:7] == '0) && bit_val;
    endfunction

endpackage

// ===== rtl/ldrs_tracker.sv =====
module ldrs_tracker
    import ldrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             start,
    input  logic             keep,
    input  logic             move,
    input  logic             done,
    input  logic [POS_W-1:0] cur,
    output lex_t             lex,
    output logic             open_next
);

    logic             open_reg;
    logic [POS_W-1:0] begin_reg;
    logic [POS_W-1:0] stop_reg;
    logic             open_upd;
    logic [POS_W-1:0] begin_upd;
    logic [POS_W-1:0] stop_upd;
    logic             close_run;
    logic             flush_run;
    logic [POS_W-1:0] begin_next;
    logic [POS_W-1:0] stop_next;

    always_comb
    begin
        open_upd  = open_reg;
        begin_upd = begin_reg;
        stop_upd  = stop_reg;
        close_run = 1'b0;
        if (!open_reg)
        begin
            if (start)
            begin
                open_upd  = 1'b1;
                begin_upd = cur;
                stop_upd  = cur;
            end
        end
        else if (keep)
        begin
            if (move)
            begin
                stop_upd = cur;
            end
        end
        else
        begin
            // The run closes with its old bounds.
            open_upd  = 1'b0;
            close_run = 1'b1;
        end
        flush_run = done && open_upd;

        lex.emit      = close_run || flush_run;
        lex.begin_pos = begin_upd;
        lex.length    = LEN_W'({1'b0, stop_upd} - {1'b0, begin_upd} + 13'd1);

        open_next  = open_upd && !flush_run;
        begin_next = lex.emit ? '0 : begin_upd;
        stop_next  = lex.emit ? '0 : stop_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            begin_reg <= '0;
            stop_reg  <= '0;
        end
        else if (step)
        begin
            open_reg  <= open_next;
            begin_reg <= begin_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

// ===== rtl/ldrs_queue.sv =====
module ldrs_queue
    import ldrs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   can_push,
    input  logic   pop,
    output logic   has_entry,
    output entry_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign can_push  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign has_entry = count_reg != '0;
    assign head      = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/ldrs_emitter.sv =====
module ldrs_emitter
    import ldrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   has_entry,
    input  entry_t                 head,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast
);

    entry_t              cur_reg;
    logic                valid_reg;
    logic [TRACKERS-1:0] pending_reg;
    logic [TRACKERS-1:0] pending_rest;
    logic [1:0]          sel;
    logic                has_lex;
    logic                last;
    logic                take;
    lex_t                lex_sel;
    logic [TYPE_W-1:0]   lex_type;
    logic [BASE_W-1:0]   out_base;
    logic [POS_W-1:0]    out_begin;
    logic [LEN_W-1:0]    out_length;
    logic [TYPE_W-1:0]   out_type;

    always_comb
    begin
        priority if (pending_reg[0])
        begin
            sel      = 2'd0;
            lex_type = TYPE_ENG;
        end
        else if (pending_reg[1])
        begin
            sel      = 2'd1;
            lex_type = TYPE_DIG;
        end
        else
        begin
            sel      = 2'd2;
            lex_type = TYPE_MIX;
        end
    end

    assign lex_sel      = cur_reg.lexes[sel];
    assign has_lex      = pending_reg != '0;
    assign pending_rest = pending_reg & (pending_reg - TRACKERS'(1));
    assign last         = pending_rest == '0;
    assign take         = valid_reg && m_axis_tready;
    assign pop          = has_entry && (!valid_reg || (take && last));

    // A result without a lexeme carries zeros in every lexeme field.
    assign out_base   = has_lex ? cur_reg.base : '0;
    assign out_begin  = has_lex ? lex_sel.begin_pos : '0;
    assign out_length = has_lex ? lex_sel.length : '0;
    assign out_type   = has_lex ? lex_type : '0;

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = last;
    assign m_axis_tuser  = {out_type, has_lex};
    assign m_axis_tdata  = {6'd0, cur_reg.lock, out_length, out_begin, out_base};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= '0;
        end
        else if (pop)
        begin
            valid_reg   <= 1'b1;
            pending_reg <= {head.lexes[2].emit, head.lexes[1].emit, head.lexes[0].emit};
        end
        else if (take)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            pending_reg <= pending_rest;
        end
    end

endmodule

// ===== rtl/letter_digit_run_segmenter_top.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata, tlast = buffer_done
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata, tuser, tlast = last_result
// cfg       in         cfg_we (no wait)               cfg_index, cfg_data
//
// An item is registered on entry and stepped through the three trackers once
// the four-entry item queue has room; one item per cycle while it has room.
// Each item gives one to three results, sent one per cycle from the output
// register, so the output side sets the rate when many items close runs.
// Reset clears the trackers, the queue and the connector masks to defaults.
// A stall on the output fills the queue and then holds the input register.
module letter_digit_run_segmenter_top
    import ldrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // char_class[1:0], char_code[17:2], cursor[29:18], segment_base[61:30]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // lexeme_base[31:0], lexeme_begin[43:32], lexeme_length[56:44], lock_buffer[57]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // has_lexeme[0], lexeme_type[2:1]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [MASK_W-1:0]      cfg_data
);

    logic [MASK_W-1:0] letter_lo_reg;
    logic [MASK_W-1:0] letter_hi_reg;
    logic [MASK_W-1:0] num_lo_reg;
    logic [MASK_W-1:0] num_hi_reg;

    logic              in_valid_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [CODE_W-1:0] code_reg;
    logic [POS_W-1:0]  cur_reg;
    logic [BASE_W-1:0] base_reg;
    logic              done_reg;

    logic   step;
    logic   can_push;
    logic   pop;
    logic   has_entry;
    entry_t head;
    entry_t entry;
    logic   is_eng;
    logic   is_dig;
    logic   is_unk;
    logic   num_conn;
    logic   letter_conn;
    logic   mix_keep;
    lex_t   eng_lex;
    lex_t   dig_lex;
    lex_t   mix_lex;
    logic   eng_open;
    logic   dig_open;
    logic   mix_open;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_lo_reg <= LETTER_LO_RST;
            letter_hi_reg <= LETTER_HI_RST;
            num_lo_reg    <= NUM_LO_RST;
            num_hi_reg    <= NUM_HI_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LETTER_LO: letter_lo_reg <= cfg_data;
                REG_LETTER_HI: letter_hi_reg <= cfg_data;
                REG_NUM_LO:    num_lo_reg    <= cfg_data;
                REG_NUM_HI:    num_hi_reg    <= cfg_data;
                default:       letter_lo_reg <= letter_lo_reg;
            endcase
        end
    end

    assign step          = in_valid_reg && can_push;
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            cls_reg  <= s_axis_tdata[1:0];
            code_reg <= s_axis_tdata[17:2];
            cur_reg  <= s_axis_tdata[29:18];
            base_reg <= s_axis_tdata[61:30];
            done_reg <= s_axis_tlast;
        end
    end

    assign is_eng      = cls_reg == CLS_ENG;
    assign is_dig      = cls_reg == CLS_DIG;
    assign is_unk      = cls_reg == CLS_UNK;
    assign num_conn    = is_unk && conn_hit(num_lo_reg, num_hi_reg, code_reg);
    assign letter_conn = is_unk && conn_hit(letter_lo_reg, letter_hi_reg, code_reg);
    assign mix_keep    = is_eng || is_dig || letter_conn;

    ldrs_tracker u_eng (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .start     (is_eng),
        .keep      (is_eng),
        .move      (is_eng),
        .done      (done_reg),
        .cur       (cur_reg),
        .lex       (eng_lex),
        .open_next (eng_open)
    );

    // Number connectors hold a digit run open but do not move its end.
    ldrs_tracker u_dig (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .start     (is_dig),
        .keep      (is_dig || num_conn),
        .move      (is_dig),
        .done      (done_reg),
        .cur       (cur_reg),
        .lex       (dig_lex),
        .open_next (dig_open)
    );

    ldrs_tracker u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .start     (is_eng || is_dig),
        .keep      (mix_keep),
        .move      (mix_keep),
        .done      (done_reg),
        .cur       (cur_reg),
        .lex       (mix_lex),
        .open_next (mix_open)
    );

    always_comb
    begin
        entry.base  = base_reg;
        entry.lock  = eng_open || dig_open || mix_open;
        entry.lexes = {mix_lex, dig_lex, eng_lex};
    end

    ldrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_entry (entry),
        .can_push   (can_push),
        .pop        (pop),
        .has_entry  (has_entry),
        .head       (head)
    );

    ldrs_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .has_entry     (has_entry),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/letter_digit_run_segmenter_top_tb.sv =====
`timescale 1ns / 100ps

module letter_digit_run_segmenter_top_tb;

    import ldrs_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [CLS_W-1:0] CLS_OTHER = 2'd3;

    localparam logic [CODE_W-1:0] CODE_LOWER_A   = 16'h0061;
    localparam logic [CODE_W-1:0] CODE_ONE       = 16'h0031;
    localparam logic [CODE_W-1:0] CODE_COMMA     = 16'h002C;
    localparam logic [CODE_W-1:0] CODE_HYPHEN    = 16'h002D;
    localparam logic [CODE_W-1:0] CODE_DOT       = 16'h002E;
    localparam logic [CODE_W-1:0] CODE_AT        = 16'h0040;
    localparam logic [CODE_W-1:0] CODE_UNDERLINE = 16'h005F;
    localparam logic [CODE_W-1:0] CODE_HIGH_DOT  = 16'h00AE;
    localparam logic [CODE_W-1:0] CODE_WIDE_DOT  = 16'h012E;
    localparam logic [CODE_W-1:0] CODE_ALL_ONES  = 16'hFFFF;

    typedef struct packed {
        logic              has_lex;
        logic [BASE_W-1:0] base;
        logic [POS_W-1:0]  first_pos;
        logic [LEN_W-1:0]  len;
        logic [TYPE_W-1:0] kind;
        logic              lock;
        logic              last;
    } lexeme_rec_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [MASK_W-1:0]      cfg_data = '0;

    letter_digit_run_segmenter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Predictor state: connector masks and the three run trackers.
    logic [MASK_W-1:0] letter_join_lo;
    logic [MASK_W-1:0] letter_join_hi;
    logic [MASK_W-1:0] number_join_lo;
    logic [MASK_W-1:0] number_join_hi;
    logic              letters_live;
    logic [POS_W-1:0]  letters_from;
    logic [POS_W-1:0]  letters_to;
    logic              digits_live;
    logic [POS_W-1:0]  digits_from;
    logic [POS_W-1:0]  digits_to;
    logic              mixed_live;
    logic [POS_W-1:0]  mixed_from;
    logic [POS_W-1:0]  mixed_to;

    lexeme_rec_t pending_lexemes[$];

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int chars_sent = 0;
    int lexemes_checked = 0;
    int error_count = 0;
    int cycle_count = 0;

    function automatic logic is_joiner(input logic [MASK_W-1:0] lo,
                                       input logic [MASK_W-1:0] hi,
                                       input logic [CODE_W-1:0] code);
        logic [2*MASK_W-1:0] both;
        both = {hi, lo};
        return (code < 16'd128) && both[code[6:0]];
    endfunction

    function automatic lexeme_rec_t make_lexeme(input logic [BASE_W-1:0] base,
                                                input logic [POS_W-1:0] from_pos,
                                                input logic [POS_W-1:0] to_pos,
                                                input logic [TYPE_W-1:0] kind);
        lexeme_rec_t r;
        r = '0;
        r.has_lex   = 1'b1;
        r.base      = base;
        r.first_pos = from_pos;
        r.len       = {1'b0, to_pos} - {1'b0, from_pos} + 13'd1;
        r.kind      = kind;
        return r;
    endfunction

    function automatic void reset_segmenter_model();
        letter_join_lo = LETTER_LO_RST;
        letter_join_hi = LETTER_HI_RST;
        number_join_lo = NUM_LO_RST;
        number_join_hi = NUM_HI_RST;
        letters_live = 1'b0;
        digits_live  = 1'b0;
        mixed_live   = 1'b0;
        letters_from = '0;
        letters_to   = '0;
        digits_from  = '0;
        digits_to    = '0;
        mixed_from   = '0;
        mixed_to     = '0;
    endfunction

    // Steps the three trackers for one accepted character and queues its results.
    function automatic void segment_char(input logic [CLS_W-1:0] cls,
                                         input logic [CODE_W-1:0] code,
                                         input logic [POS_W-1:0] cur,
                                         input logic [BASE_W-1:0] base,
                                         input logic done);
        lexeme_rec_t found[$];
        lexeme_rec_t idle_rec;
        logic is_let;
        logic is_dig;
        logic is_unk;
        logic any_open;
        is_let = (cls == CLS_ENG);
        is_dig = (cls == CLS_DIG);
        is_unk = (cls == CLS_UNK);

        if (!letters_live)
        begin
            if (is_let)
            begin
                letters_live = 1'b1;
                letters_from = cur;
                letters_to   = cur;
            end
        end
        else if (is_let)
            letters_to = cur;
        else
        begin
            found.push_back(make_lexeme(base, letters_from, letters_to, TYPE_ENG));
            letters_live = 1'b0;
        end
        if (done && letters_live)
        begin
            found.push_back(make_lexeme(base, letters_from, letters_to, TYPE_ENG));
            letters_live = 1'b0;
        end

        // A number connector keeps the digit run open but does not move its end.
        if (!digits_live)
        begin
            if (is_dig)
            begin
                digits_live = 1'b1;
                digits_from = cur;
                digits_to   = cur;
            end
        end
        else if (is_dig)
            digits_to = cur;
        else if (!(is_unk && is_joiner(number_join_lo, number_join_hi, code)))
        begin
            found.push_back(make_lexeme(base, digits_from, digits_to, TYPE_DIG));
            digits_live = 1'b0;
        end
        if (done && digits_live)
        begin
            found.push_back(make_lexeme(base, digits_from, digits_to, TYPE_DIG));
            digits_live = 1'b0;
        end

        if (!mixed_live)
        begin
            if (is_let || is_dig)
            begin
                mixed_live = 1'b1;
                mixed_from = cur;
                mixed_to   = cur;
            end
        end
        else if (is_let || is_dig ||
                 (is_unk && is_joiner(letter_join_lo, letter_join_hi, code)))
            mixed_to = cur;
        else
        begin
            found.push_back(make_lexeme(base, mixed_from, mixed_to, TYPE_MIX));
            mixed_live = 1'b0;
        end
        if (done && mixed_live)
        begin
            found.push_back(make_lexeme(base, mixed_from, mixed_to, TYPE_MIX));
            mixed_live = 1'b0;
        end

        any_open = letters_live | digits_live | mixed_live;
        if (found.size() == 0)
        begin
            idle_rec = '0;
            found.push_back(idle_rec);
        end
        foreach (found[i])
        begin
            found[i].lock = any_open;
            found[i].last = (i == found.size() - 1);
            pending_lexemes.push_back(found[i]);
        end
    endfunction

    function automatic void check_lexeme();
        lexeme_rec_t want;
        if (pending_lexemes.size() == 0)
        begin
            $error("result with no expectation: tdata=%h tuser=%h tlast=%b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            error_count++;
            return;
        end
        want = pending_lexemes.pop_front();
        lexemes_checked++;
        if (m_axis_tuser[0] !== want.has_lex)
        begin
            $error("has_lexeme: expected %0d, got %0d", want.has_lex, m_axis_tuser[0]);
            error_count++;
        end
        if (m_axis_tdata[31:0] !== want.base)
        begin
            $error("lexeme_base: expected %h, got %h", want.base, m_axis_tdata[31:0]);
            error_count++;
        end
        if (m_axis_tdata[43:32] !== want.first_pos)
        begin
            $error("lexeme_begin: expected %0d, got %0d", want.first_pos,
                   m_axis_tdata[43:32]);
            error_count++;
        end
        if (m_axis_tdata[56:44] !== want.len)
        begin
            $error("lexeme_length: expected %0d, got %0d", want.len, m_axis_tdata[56:44]);
            error_count++;
        end
        if (m_axis_tuser[2:1] !== want.kind)
        begin
            $error("lexeme_type: expected %0d, got %0d", want.kind, m_axis_tuser[2:1]);
            error_count++;
        end
        if (m_axis_tdata[57] !== want.lock)
        begin
            $error("lock_buffer: expected %0d, got %0d", want.lock, m_axis_tdata[57]);
            error_count++;
        end
        if (m_axis_tlast !== want.last)
        begin
            $error("last_result: expected %0d, got %0d", want.last, m_axis_tlast);
            error_count++;
        end
    endfunction

    // Output side: values read at the edge are the ones from before it.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_lexeme();
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("letter_digit_run_segmenter_top: mismatch");
        $finish;
    end

    // Leaves tvalid high on return so that back-to-back items need no extra step.
    task automatic send_char(input logic [CLS_W-1:0] cls,
                             input logic [CODE_W-1:0] code,
                             input logic [POS_W-1:0] cur,
                             input logic [BASE_W-1:0] base,
                             input logic done);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, base, cur, code, cls};
        s_axis_tlast  <= done;
        do
            @(posedge clk);
        while (!s_axis_tready);
        segment_char(cls, code, cur, base, done);
        chars_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_lexemes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_masks(input logic [MASK_W-1:0] let_lo,
                               input logic [MASK_W-1:0] let_hi,
                               input logic [MASK_W-1:0] num_lo,
                               input logic [MASK_W-1:0] num_hi);
        logic [MASK_W-1:0] vals[4];
        logic [CFG_IDX_W-1:0] regs[4];
        vals = '{let_lo, let_hi, num_lo, num_hi};
        regs = '{REG_LETTER_LO, REG_LETTER_HI, REG_NUM_LO, REG_NUM_HI};
        wait_idle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            unique case (regs[i])
                REG_LETTER_LO: letter_join_lo = vals[i];
                REG_LETTER_HI: letter_join_hi = vals[i];
                REG_NUM_LO:    number_join_lo = vals[i];
                REG_NUM_HI:    number_join_hi = vals[i];
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        logic [CODE_W-1:0] joiners[6];
        joiners = '{CODE_COMMA, CODE_HYPHEN, CODE_DOT, CODE_AT, CODE_UNDERLINE,
                    CODE_HIGH_DOT};
        case ($urandom_range(3))
            0, 1: return 16'($urandom_range(127));
            2:    return joiners[$urandom_range(5)];
            default: return 16'($urandom);
        endcase
    endfunction

    // One buffer of consecutive positions, mostly letters and digits, closed by done.
    task automatic send_random_buffer(input int n_chars);
        logic [BASE_W-1:0] base;
        logic [POS_W-1:0] cur;
        logic [CLS_W-1:0] cls;
        int pick;
        base = $urandom;
        cur  = 12'($urandom_range(4095));
        for (int k = 0; k < n_chars; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                cls = CLS_ENG;
            else if (pick < 70)
                cls = CLS_DIG;
            else if (pick < 92)
                cls = CLS_UNK;
            else
                cls = CLS_OTHER;
            send_char(cls, random_code(), cur, base, k == n_chars - 1);
            cur = cur + 12'd1;
        end
    endtask

    // Buffers are cut short near the end so that exactly n_items are sent.
    task automatic run_stream(input int n_items);
        int start;
        int left;
        start = chars_sent;
        while (chars_sent - start < n_items)
        begin
            left = n_items - (chars_sent - start);
            if ($urandom_range(9) < 8)
                send_random_buffer($urandom_range(1, (left < 12) ? left : 12));
            else
                send_char(2'($urandom_range(3)), 16'($urandom), 12'($urandom),
                          $urandom, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_directed();
        // Letters, digits, connectors and a flush at the end of the buffer.
        send_char(CLS_ENG, CODE_LOWER_A, 12'd0, 32'h0000_0000, 1'b0);
        send_char(CLS_ENG, CODE_LOWER_A, 12'd1, 32'h0000_0000, 1'b0);
        send_char(CLS_DIG, CODE_ONE, 12'd2, 32'h0000_0000, 1'b0);
        send_char(CLS_UNK, CODE_COMMA, 12'd3, 32'h0000_0000, 1'b0);
        send_char(CLS_DIG, CODE_ONE, 12'd4, 32'h0000_0000, 1'b0);
        send_char(CLS_UNK, CODE_DOT, 12'd5, 32'h0000_0000, 1'b0);
        send_char(CLS_UNK, CODE_HYPHEN, 12'd6, 32'h0000_0000, 1'b0);
        send_char(CLS_ENG, CODE_LOWER_A, 12'd7, 32'h0000_0000, 1'b1);
        // Class other with nothing open, then a cursor that goes backward.
        send_char(CLS_OTHER, CODE_ALL_ONES, 12'd0, 32'hFFFF_FFFF, 1'b0);
        send_char(CLS_DIG, CODE_ONE, 12'd4095, 32'hFFFF_FFFF, 1'b0);
        send_char(CLS_ENG, CODE_LOWER_A, 12'd0, 32'hFFFF_FFFF, 1'b0);
        // Codes above ASCII whose low bits name a connector are not connectors.
        send_char(CLS_UNK, CODE_HIGH_DOT, 12'd1, 32'hFFFF_FFFF, 1'b0);
        send_char(CLS_ENG, CODE_LOWER_A, 12'd10, 32'h1234_5678, 1'b0);
        send_char(CLS_DIG, CODE_ONE, 12'd11, 32'h1234_5678, 1'b0);
        send_char(CLS_UNK, CODE_WIDE_DOT, 12'd12, 32'h1234_5678, 1'b0);
        // A digit that ends the buffer after letters gives all three lexemes.
        send_char(CLS_ENG, CODE_LOWER_A, 12'd20, 32'h8000_0000, 1'b0);
        send_char(CLS_ENG, CODE_LOWER_A, 12'd21, 32'h8000_0000, 1'b0);
        send_char(CLS_DIG, CODE_ONE, 12'd22, 32'h8000_0000, 1'b1);
        send_char(CLS_UNK, CODE_ALL_ONES, 12'd5, 32'h8000_0000, 1'b1);
        // Runs closed by a mismatch are not flushed a second time at the end.
        send_char(CLS_ENG, CODE_LOWER_A, 12'd100, 32'h0000_0001, 1'b0);
        send_char(CLS_UNK, CODE_UNDERLINE, 12'd101, 32'h0000_0001, 1'b0);
        send_char(CLS_UNK, CODE_AT, 12'd102, 32'h0000_0001, 1'b0);
        send_char(CLS_OTHER, CODE_LOWER_A, 12'd103, 32'h0000_0001, 1'b1);
        send_char(CLS_DIG, CODE_ONE, 12'd200, 32'h7FFF_FFFF, 1'b0);
        send_char(CLS_UNK, CODE_COMMA, 12'd201, 32'h7FFF_FFFF, 1'b1);
    endtask

    task automatic test_default_masks();
        run_stream(40);
        // The sender holds off here until the block has delivered everything.
        wait_idle();
        run_stream(40);
    endtask

    task automatic test_open_masks();
        write_masks('1, '1, '1, '1);
        run_stream(45);
    endtask

    task automatic test_closed_masks();
        write_masks('0, '0, '0, '0);
        run_stream(40);
    endtask

    task automatic test_random_masks();
        write_masks({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_stream(40);
    endtask

    initial
    begin
        reset_segmenter_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 10;
        dst_idle_pct = 61;
        test_directed();
        test_default_masks();

        src_idle_pct = 61;
        dst_idle_pct = 10;
        test_open_masks();
        test_closed_masks();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_masks();

        wait_idle();
        if (pending_lexemes.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_lexemes.size());
            error_count++;
        end
        $display("Sent %0d characters and checked %0d results under default, open, closed",
                 chars_sent, lexemes_checked);
        $display("and random connector masks, with idle gaps on both sides and none.");
        if (error_count == 0)
            $display("letter_digit_run_segmenter_top: match");
        else
            $display("letter_digit_run_segmenter_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ldrs_pkg.sv
rtl/ldrs_tracker.sv
rtl/ldrs_queue.sv
rtl/ldrs_emitter.sv
rtl/letter_digit_run_segmenter_top.sv
tb/letter_digit_run_segmenter_top_tb.sv
